// ===== rtl/core/hkvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkvt_pkg
// Types, codes and the hash step sequence shared by the keyed table block.
// ----------------------------------------------------------------------------
package hkvt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_DELETED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  key_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key_hash;
  } out_item_t;

  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_CLEAR,
    HOP_ADD_BYTE,
    HOP_ADD_SHL,
    HOP_XOR_SHR
  } hash_op_t;

  typedef struct packed {
    hash_op_t    op;
    logic [3:0]  shamt;
    logic [7:0]  key_byte;
  } hash_cmd_t;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_BYTE,
    FS_FINAL,
    FS_LATCH,
    FS_SCAN,
    FS_APPLY
  } fsm_t;

  typedef struct packed {
    logic        rd_en;
    logic        ent_we;
    logic        val_we;
    logic        ent_valid;
  } tbl_req_t;

  localparam logic [1:0] LAST_STEP = 2'd2;

  // Per-byte mix is add byte, add shl 10, xor shr 6; final mix is
  // add shl 3, xor shr 11, add shl 15.
  function automatic hash_cmd_t hash_step(input logic is_final, input logic [1:0] step);
    hash_cmd_t c;
    c.key_byte = 8'd0;
    c.op       = HOP_NONE;
    c.shamt    = 4'd0;
    case ({is_final, step})
      3'b000: c.op = HOP_ADD_BYTE;
      3'b001: begin
        c.op    = HOP_ADD_SHL;
        c.shamt = 4'd10;
      end
      3'b010: begin
        c.op    = HOP_XOR_SHR;
        c.shamt = 4'd6;
      end
      3'b100: begin
        c.op    = HOP_ADD_SHL;
        c.shamt = 4'd3;
      end
      3'b101: begin
        c.op    = HOP_XOR_SHR;
        c.shamt = 4'd11;
      end
      3'b110: begin
        c.op    = HOP_ADD_SHL;
        c.shamt = 4'd15;
      end
      default: c.op = HOP_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hkvt_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkvt_hash
// Hash accumulator with one shared add / shift / xor unit, one op per cycle.
// ----------------------------------------------------------------------------
module hkvt_hash (
  input  wire                   clk,
  input  wire                   rst_n,
  input  hkvt_pkg::hash_cmd_t   cmd,
  output logic [31:0]           acc
);
  import hkvt_pkg::*;

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;

  always_comb begin
    case (cmd.op)
      HOP_CLEAR:    acc_nxt = 32'd0;
      HOP_ADD_BYTE: acc_nxt = acc_r + {24'd0, cmd.key_byte};
      HOP_ADD_SHL:  acc_nxt = acc_r + (acc_r << cmd.shamt);
      HOP_XOR_SHR:  acc_nxt = acc_r ^ (acc_r >> cmd.shamt);
      default:      acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== rtl/core/hkvt_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkvt_table
// Entry store: valid bit and hash in one memory, values in another.
// One access per cycle, registered read data.
// ----------------------------------------------------------------------------
module hkvt_table #(
  parameter int TABLE_DEPTH = hkvt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire                           clk,
  input  hkvt_pkg::tbl_req_t            req,
  input  wire [$clog2(TABLE_DEPTH)-1:0] addr,
  input  wire [31:0]                    wr_hash,
  input  wire [31:0]                    wr_value,
  output logic                          rd_valid,
  output logic [31:0]                   rd_hash
);
  import hkvt_pkg::*;

  logic [32:0] ent_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];
  logic [32:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      ent_mem[addr] <= {req.ent_valid, wr_hash};
    end
    if (req.rd_en) begin
      rd_data_r <= ent_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      val_mem[addr] <= wr_value;
    end
  end

  assign rd_valid = rd_data_r[32];
  assign rd_hash  = rd_data_r[31:0];

endmodule
`default_nettype wire

// ===== rtl/core/hashed_key_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_key_value_table
// Key bytes are hashed one-at-a-time style; the last beat runs insert,
// delete or search against a table scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Sequence: a key byte beat is the accept cycle, then the add byte, add shl
// and xor shr steps in the shared hash unit (only the accept if the byte is
// not valid). A last beat adds the final mix, a latch state, a scan of every
// entry plus a closing state and an update; out_valid pulses the cycle after.
// A new beat is taken only in idle, once the last one is done. Reset clears
// every entry with busy high. Results cannot be stalled by the receiver.
module hashed_key_value_table #(
  parameter int TABLE_DEPTH = hkvt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  hkvt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output hkvt_pkg::out_item_t  out_data
);
  import hkvt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] SCAN_END  = CW'(TABLE_DEPTH);

  fsm_t       state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  in_item_t   item_r;
  logic [31:0] hash_r;
  logic        rd_pend_r;
  logic [AW-1:0] rd_idx_r;
  logic        match_hit_r, free_hit_r;
  logic [AW-1:0] match_idx_r, free_idx_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  hash_cmd_t   hcmd;
  logic [31:0] acc;
  tbl_req_t    treq;
  logic [AW-1:0] taddr;
  logic        rd_valid;
  logic [31:0] rd_hash;
  status_t     status;
  logic        accept;

  assign accept = start && !busy;

  hkvt_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hcmd),
    .acc   (acc)
  );

  hkvt_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .req      (treq),
    .addr     (taddr),
    .wr_hash  (hash_r),
    .wr_value (item_r.new_value),
    .rd_valid (rd_valid),
    .rd_hash  (rd_hash)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_CLEAR: begin
        if (scan_r[AW-1:0] == LAST_IDX) state_nxt = FS_IDLE;
      end
      FS_IDLE: begin
        if (accept) begin
          if (in_data.byte_valid)     state_nxt = FS_BYTE;
          else if (in_data.last_byte) state_nxt = FS_FINAL;
        end
      end
      FS_BYTE: begin
        if (step_r == LAST_STEP) state_nxt = item_r.last_byte ? FS_FINAL : FS_IDLE;
      end
      FS_FINAL: begin
        if (step_r == LAST_STEP) state_nxt = FS_LATCH;
      end
      FS_LATCH: state_nxt = FS_SCAN;
      FS_SCAN: begin
        if (scan_r == SCAN_END) state_nxt = FS_APPLY;
      end
      FS_APPLY: state_nxt = FS_IDLE;
      default:  state_nxt = FS_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    hcmd          = '{op: HOP_NONE, shamt: 4'd0, key_byte: 8'd0};
    treq          = '0;
    taddr         = scan_r[AW-1:0];
    status        = ST_NOT_FOUND;
    step_nxt      = 2'd0;
    scan_nxt      = '0;
    case (state_r)
      FS_CLEAR: begin
        treq.ent_we = 1'b1;
        scan_nxt    = (scan_r[AW-1:0] == LAST_IDX) ? '0 : scan_r + 1'b1;
      end
      FS_BYTE: begin
        hcmd          = hash_step(1'b0, step_r);
        hcmd.key_byte = item_r.key_byte;
        step_nxt      = (step_r == LAST_STEP) ? 2'd0 : step_r + 2'd1;
      end
      FS_FINAL: begin
        hcmd     = hash_step(1'b1, step_r);
        step_nxt = (step_r == LAST_STEP) ? 2'd0 : step_r + 2'd1;
      end
      FS_LATCH: hcmd.op = HOP_CLEAR;
      FS_SCAN: begin
        treq.rd_en = (scan_r != SCAN_END);
        scan_nxt   = (scan_r == SCAN_END) ? '0 : scan_r + 1'b1;
      end
      FS_APPLY: begin
        taddr = match_hit_r ? match_idx_r : free_idx_r;
        case (item_r.cmd)
          CMD_INSERT: begin
            if (match_hit_r) begin
              treq.val_we = 1'b1;
              status      = ST_UPDATED;
            end else if (free_hit_r) begin
              treq.ent_we    = 1'b1;
              treq.ent_valid = 1'b1;
              treq.val_we    = 1'b1;
              status         = ST_INSERTED;
            end else begin
              status = ST_FULL;
            end
          end
          CMD_DELETE: begin
            if (match_hit_r) begin
              treq.ent_we = 1'b1;
              status      = ST_DELETED;
            end
          end
          default: status = match_hit_r ? ST_FOUND : ST_NOT_FOUND;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_CLEAR;
      step_r      <= 2'd0;
      scan_r      <= '0;
      rd_pend_r   <= 1'b0;
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      scan_r      <= scan_nxt;
      rd_pend_r   <= treq.rd_en;
      out_valid_r <= (state_r == FS_APPLY);
      if (state_r == FS_LATCH) begin
        match_hit_r <= 1'b0;
        free_hit_r  <= 1'b0;
      end else if (rd_pend_r) begin
        // keep the lowest index of each kind
        if (!match_hit_r && rd_valid && (rd_hash == hash_r)) begin
          match_hit_r <= 1'b1;
        end
        if (!free_hit_r && !rd_valid) begin
          free_hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == FS_LATCH) begin
      hash_r <= acc;
    end
    rd_idx_r <= scan_r[AW-1:0];
    if (rd_pend_r) begin
      if (!match_hit_r && rd_valid && (rd_hash == hash_r)) begin
        match_idx_r <= rd_idx_r;
      end
      if (!free_hit_r && !rd_valid) begin
        free_idx_r <= rd_idx_r;
      end
    end
    if (state_r == FS_APPLY) begin
      out_data_r.status   <= status;
      out_data_r.key_hash <= hash_r;
    end
  end

  assign busy      = (state_r != FS_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
